FILE: hw/rtl/kprd_pkg.sv
package kprd_pkg;

  localparam int KEY_FIELDS    = 6;
  localparam int KEY_SLOTS_DEF = 6;
  localparam int CODE_W        = 8;
  localparam int COUNT_W       = 3;

  typedef logic [CODE_W-1:0] code_t;

  typedef enum logic {
    ACT_PRESS   = 1'b0,
    ACT_RELEASE = 1'b1
  } action_t;

  typedef struct packed {
    logic [COUNT_W-1:0]               count;
    logic [KEY_FIELDS-1:0][CODE_W-1:0] keys;
  } msg_t;

endpackage

FILE: hw/rtl/kprd_lane.sv
module kprd_lane #(
  parameter int SLOTS = kprd_pkg::KEY_SLOTS_DEF
) (
  input  kprd_pkg::code_t cur_code,
  input  kprd_pkg::code_t prev_code,
  input  kprd_pkg::code_t cur_set [SLOTS],
  input  kprd_pkg::code_t prev_set [SLOTS],
  output logic            press_hit,
  output logic            release_hit
);
  import kprd_pkg::*;

  logic in_prev;
  logic in_cur;

  always_comb begin
    in_prev = 1'b0;
    in_cur  = 1'b0;
    for (int j = 0; j < SLOTS; j++) begin
      if (prev_set[j] == cur_code) begin
        in_prev = 1'b1;
      end
      if (cur_set[j] == prev_code) begin
        in_cur = 1'b1;
      end
    end
    press_hit   = (cur_code != '0) && !in_prev;
    release_hit = (prev_code != '0) && !in_cur;
  end

endmodule

FILE: hw/rtl/kprd_pack.sv
module kprd_pack #(
  parameter int SLOTS = kprd_pkg::KEY_SLOTS_DEF
) (
  input  kprd_pkg::code_t    codes [SLOTS],
  input  logic [SLOTS-1:0]   flags,
  output kprd_pkg::msg_t     msg
);
  import kprd_pkg::*;

  logic [COUNT_W-1:0] n;

  // slot-order compaction, saturating at the field count
  always_comb begin
    n   = '0;
    msg = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (flags[i] && (n < COUNT_W'(KEY_FIELDS))) begin
        msg.keys[n] = codes[i];
        n = n + COUNT_W'(1);
      end
    end
    msg.count = n;
  end

endmodule

FILE: hw/rtl/key_set_press_release_diff.sv
// Key set press/release detector. Each snapshot (key_0..key_5, 0 = empty slot) is compared
// as a set with the stored previous snapshot by one lane per slot, and a packing stage lists
// new codes in a press message and vanished codes in a release message, in that order, with
// last set on the final one. A new snapshot is taken when the held one has no message left
// or its final message enters the output register, which carries one message per cycle
// while msg_ready does not hold it back. Snapshots are registered in the s1 stage first. A
// snapshot that yields no message is absorbed without any output.
module key_set_press_release_diff #(
  parameter int KEY_SLOTS = kprd_pkg::KEY_SLOTS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            key_valid,
  output logic            key_ready,
  input  kprd_pkg::code_t key_0,
  input  kprd_pkg::code_t key_1,
  input  kprd_pkg::code_t key_2,
  input  kprd_pkg::code_t key_3,
  input  kprd_pkg::code_t key_4,
  input  kprd_pkg::code_t key_5,
  output logic            msg_valid,
  input  logic            msg_ready,
  output logic            action,
  output logic [2:0]      key_count,
  output kprd_pkg::code_t out_key_0,
  output kprd_pkg::code_t out_key_1,
  output kprd_pkg::code_t out_key_2,
  output kprd_pkg::code_t out_key_3,
  output kprd_pkg::code_t out_key_4,
  output kprd_pkg::code_t out_key_5,
  output logic            last
);
  import kprd_pkg::*;

  code_t key_in [KEY_FIELDS];
  code_t cur    [KEY_SLOTS];
  code_t prev   [KEY_SLOTS];
  logic [KEY_SLOTS-1:0] press_flag;
  logic [KEY_SLOTS-1:0] rel_flag;

  code_t s1_cur  [KEY_SLOTS];
  code_t s1_prev [KEY_SLOTS];
  logic [KEY_SLOTS-1:0] s1_press;
  logic [KEY_SLOTS-1:0] s1_rel;
  logic s1_valid;
  logic phase;

  msg_t press_msg;
  msg_t rel_msg;

  action_t action_reg;
  logic [COUNT_W-1:0] count_reg;
  logic [KEY_FIELDS-1:0][CODE_W-1:0] okeys;
  logic last_reg;

  logic press_has, rel_has, emit_press, emit_rel, emit, emit_last;
  logic out_load, s1_done, accept;

  assign key_in[0] = key_0;
  assign key_in[1] = key_1;
  assign key_in[2] = key_2;
  assign key_in[3] = key_3;
  assign key_in[4] = key_4;
  assign key_in[5] = key_5;

  for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_slot
    if (g < KEY_FIELDS) begin : g_field
      assign cur[g] = key_in[g];
    end else begin : g_empty
      assign cur[g] = '0;
    end

    kprd_lane #(.SLOTS(KEY_SLOTS)) u_lane (
      .cur_code    (cur[g]),
      .prev_code   (prev[g]),
      .cur_set     (cur),
      .prev_set    (prev),
      .press_hit   (press_flag[g]),
      .release_hit (rel_flag[g])
    );
  end

  kprd_pack #(.SLOTS(KEY_SLOTS)) u_pack_press (
    .codes (s1_cur),
    .flags (s1_press),
    .msg   (press_msg)
  );

  kprd_pack #(.SLOTS(KEY_SLOTS)) u_pack_rel (
    .codes (s1_prev),
    .flags (s1_rel),
    .msg   (rel_msg)
  );

  always_comb begin
    press_has  = |s1_press;
    rel_has    = |s1_rel;
    emit_press = s1_valid && !phase && press_has;
    emit_rel   = s1_valid && !emit_press && rel_has;
    emit       = emit_press || emit_rel;
    emit_last  = emit_rel || !rel_has;
    out_load   = !msg_valid || msg_ready;
    s1_done    = s1_valid && (!emit || (out_load && emit_last));
    key_ready  = !s1_valid || s1_done;
    accept     = key_valid && key_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      phase     <= 1'b0;
      msg_valid <= 1'b0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        prev[i] <= '0;
      end
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        phase    <= 1'b0;
        prev     <= cur;
      end else if (s1_done) begin
        s1_valid <= 1'b0;
        phase    <= 1'b0;
      end else if (emit_press && out_load) begin
        phase <= 1'b1;
      end
      if (out_load) begin
        msg_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cur   <= cur;
      s1_prev  <= prev;
      s1_press <= press_flag;
      s1_rel   <= rel_flag;
    end
    if (out_load && emit) begin
      action_reg <= emit_press ? ACT_PRESS : ACT_RELEASE;
      count_reg  <= emit_press ? press_msg.count : rel_msg.count;
      okeys      <= emit_press ? press_msg.keys : rel_msg.keys;
      last_reg   <= emit_last;
    end
  end

  assign action    = action_reg;
  assign key_count = count_reg;
  assign out_key_0 = okeys[0];
  assign out_key_1 = okeys[1];
  assign out_key_2 = okeys[2];
  assign out_key_3 = okeys[3];
  assign out_key_4 = okeys[4];
  assign out_key_5 = okeys[5];
  assign last      = last_reg;

  // second message of a snapshot is pending only while that snapshot is held
  a_phase_held: assert property (@(posedge clk) disable iff (rst)
    phase |-> s1_valid)
    else $error("release pending without a held snapshot");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    msg_valid |-> (key_count != '0) && (key_count <= COUNT_W'(KEY_FIELDS)))
    else $error("message count out of range");

  // a press that is not last is followed at once by the closing release
  a_release_follows: assert property (@(posedge clk) disable iff (rst)
    (msg_valid && msg_ready && (action_reg == ACT_PRESS) && !last_reg)
      |=> (msg_valid && (action_reg == ACT_RELEASE) && last_reg))
    else $error("release message missing after non-final press");

endmodule

FILE: bench/key_set_press_release_diff_test.sv
`timescale 1ns / 1ps

module key_set_press_release_diff_test;
  import kprd_pkg::*;

  typedef logic [KEY_FIELDS-1:0][CODE_W-1:0] snap_t;

  typedef struct packed {
    action_t            act;
    logic [COUNT_W-1:0] count;
    snap_t              keys;
    logic               last;
  } msg_exp_t;

  typedef struct packed {
    snap_t    keys;
    logic     typed;
    logic [1:0] n;
    msg_exp_t e0;
    msg_exp_t e1;
  } snap_row_t;

  localparam msg_exp_t NO_MSG = '0;
  localparam int DIR_ROWS = 17;
  localparam int RANDOM_ITEMS = 850;

  // keys are written slot 5 first, slot 0 last
  localparam snap_row_t DIRECTED_ROWS [DIR_ROWS] = '{
    '{48'h0000_0000_0000, 1'b1, 2'd0, NO_MSG, NO_MSG},
    '{48'h0000_0000_0001, 1'b1, 2'd1,
      '{ACT_PRESS, 3'd1, 48'h0000_0000_0001, 1'b1}, NO_MSG},
    '{48'h0000_0000_0001, 1'b1, 2'd0, NO_MSG, NO_MSG},
    '{48'h0000_0000_0100, 1'b1, 2'd0, NO_MSG, NO_MSG},
    '{48'hFFFF_FFFF_FFFF, 1'b1, 2'd2,
      '{ACT_PRESS, 3'd6, 48'hFFFF_FFFF_FFFF, 1'b0},
      '{ACT_RELEASE, 3'd1, 48'h0000_0000_0001, 1'b1}},
    '{48'h0000_0000_0000, 1'b1, 2'd1,
      '{ACT_RELEASE, 3'd6, 48'hFFFF_FFFF_FFFF, 1'b1}, NO_MSG},
    '{48'h0408_1020_4080, 1'b1, 2'd1,
      '{ACT_PRESS, 3'd6, 48'h0408_1020_4080, 1'b1}, NO_MSG},
    '{48'hFBFD_FE7F_0102, 1'b0, 2'd0, NO_MSG, NO_MSG},
    '{48'h0000_0000_0201, 1'b0, 2'd0, NO_MSG, NO_MSG},
    '{48'h0000_5555_0201, 1'b0, 2'd0, NO_MSG, NO_MSG},
    '{48'hAA00_0055_0000, 1'b0, 2'd0, NO_MSG, NO_MSG},
    '{48'h0000_0000_55AA, 1'b0, 2'd0, NO_MSG, NO_MSG},
    '{48'h55AA_55AA_55AA, 1'b0, 2'd0, NO_MSG, NO_MSG},
    '{48'h0100_0000_0000, 1'b0, 2'd0, NO_MSG, NO_MSG},
    '{48'h7F7F_7F7F_7F7F, 1'b0, 2'd0, NO_MSG, NO_MSG},
    '{48'h0000_0000_0080, 1'b0, 2'd0, NO_MSG, NO_MSG},
    '{48'h0000_0000_0000, 1'b0, 2'd0, NO_MSG, NO_MSG}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       key_valid = 1'b0;
  logic       key_ready;
  code_t      key_0 = '0;
  code_t      key_1 = '0;
  code_t      key_2 = '0;
  code_t      key_3 = '0;
  code_t      key_4 = '0;
  code_t      key_5 = '0;
  logic       msg_valid;
  logic       msg_ready = 1'b0;
  logic       action;
  logic [2:0] key_count;
  code_t      out_key_0;
  code_t      out_key_1;
  code_t      out_key_2;
  code_t      out_key_3;
  code_t      out_key_4;
  code_t      out_key_5;
  logic       last;

  snap_row_t snapshot_q[$];
  msg_exp_t  pending_msgs[$];
  snap_t     held_keys = '0;
  snap_t     gen_keys = '0;
  int        total_items = 0;
  int        accepted_items = 0;
  int        errors = 0;
  int        src_idle;
  int        dst_idle;

  key_set_press_release_diff u_top (
    .clk       (clk),
    .rst       (rst),
    .key_valid (key_valid),
    .key_ready (key_ready),
    .key_0     (key_0),
    .key_1     (key_1),
    .key_2     (key_2),
    .key_3     (key_3),
    .key_4     (key_4),
    .key_5     (key_5),
    .msg_valid (msg_valid),
    .msg_ready (msg_ready),
    .action    (action),
    .key_count (key_count),
    .out_key_0 (out_key_0),
    .out_key_1 (out_key_1),
    .out_key_2 (out_key_2),
    .out_key_3 (out_key_3),
    .out_key_4 (out_key_4),
    .out_key_5 (out_key_5),
    .last      (last)
  );

  always #10 clk = ~clk;

  // codes of src found in no slot of other, packed in slot order
  function automatic msg_exp_t list_absent(snap_t src, snap_t other, action_t kind);
    msg_exp_t m;
    int       n;
    bit       found;
    m = '0;
    n = 0;
    for (int i = 0; i < KEY_FIELDS; i++) begin
      if (src[i] != '0) begin
        found = 1'b0;
        for (int j = 0; j < KEY_FIELDS; j++) begin
          if (other[j] == src[i]) found = 1'b1;
        end
        if (!found && n < KEY_FIELDS) begin
          m.keys[n] = src[i];
          n++;
        end
      end
    end
    m.act = kind;
    m.count = n[COUNT_W-1:0];
    return m;
  endfunction

  function automatic int diff_snapshot(snap_t cur, output msg_exp_t first,
                                       output msg_exp_t second);
    msg_exp_t found [2];
    msg_exp_t m;
    int       n;
    found[0] = '0;
    found[1] = '0;
    n = 0;
    if (cur != held_keys) begin
      m = list_absent(cur, held_keys, ACT_PRESS);
      if (m.count != '0) begin
        found[n] = m;
        n++;
      end
      m = list_absent(held_keys, cur, ACT_RELEASE);
      if (m.count != '0) begin
        found[n] = m;
        n++;
      end
      if (n > 0) found[n-1].last = 1'b1;
    end
    held_keys = cur;
    first = found[0];
    second = found[1];
    return n;
  endfunction

  function automatic code_t pick_code();
    if ($urandom_range(99) < 60) return code_t'($urandom_range(15, 1));
    return code_t'($urandom_range(255, 1));
  endfunction

  // mostly small edits of the last snapshot, some wholesale changes
  function automatic snap_t next_snapshot(snap_t prev);
    snap_t s;
    int    r;
    int    a;
    int    b;
    code_t t;
    s = prev;
    r = $urandom_range(99);
    if (r < 30) begin
      s[$urandom_range(KEY_FIELDS-1)] = pick_code();
    end else if (r < 55) begin
      s[$urandom_range(KEY_FIELDS-1)] = '0;
    end else if (r < 70) begin
      a = $urandom_range(KEY_FIELDS-1);
      b = $urandom_range(KEY_FIELDS-1);
      t = s[a];
      s[a] = s[b];
      s[b] = t;
    end else if (r < 78) begin
      s = prev;
    end else if (r < 80) begin
      s = '0;
    end else if (r < 90) begin
      for (int i = 0; i < KEY_FIELDS; i++)
        s[i] = ($urandom_range(2) == 0) ? '0 : code_t'($urandom_range(7));
    end else begin
      for (int i = 0; i < KEY_FIELDS; i++) s[i] = code_t'($urandom_range(255));
    end
    return s;
  endfunction

  task automatic check_field(string name, int unsigned expv, int unsigned actv);
    if (expv != actv) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, expv, actv);
      errors++;
    end
  endtask

  // idling split into three equal stretches of the run
  always_comb begin
    if (accepted_items < total_items / 3) begin
      src_idle = 33;
      dst_idle = 51;
    end else if (accepted_items < 2 * total_items / 3) begin
      src_idle = 51;
      dst_idle = 33;
    end else begin
      src_idle = 0;
      dst_idle = 0;
    end
  end

  always @(posedge clk) begin : drive_snapshots
    snap_row_t item;
    msg_exp_t  m0;
    msg_exp_t  m1;
    int        n;
    if (rst) begin
      key_valid <= 1'b0;
    end else begin
      if (key_valid && key_ready) begin
        item = snapshot_q.pop_front();
        accepted_items++;
        n = diff_snapshot(item.keys, m0, m1);
        if (item.typed) begin
          n = item.n;
          m0 = item.e0;
          m1 = item.e1;
        end
        if (n > 0) pending_msgs.push_back(m0);
        if (n > 1) pending_msgs.push_back(m1);
      end
      if (!(key_valid && !key_ready)) begin
        if (snapshot_q.size() > 0 && $urandom_range(99) >= src_idle) begin
          key_valid <= 1'b1;
          key_0 <= snapshot_q[0].keys[0];
          key_1 <= snapshot_q[0].keys[1];
          key_2 <= snapshot_q[0].keys[2];
          key_3 <= snapshot_q[0].keys[3];
          key_4 <= snapshot_q[0].keys[4];
          key_5 <= snapshot_q[0].keys[5];
        end else begin
          key_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) msg_ready <= 1'b0;
    else msg_ready <= ($urandom_range(99) >= dst_idle);
  end

  always @(posedge clk) begin : check_messages
    msg_exp_t want;
    snap_t    got;
    if (!rst && msg_valid && msg_ready) begin
      if (pending_msgs.size() == 0) begin
        $display("%0t: unexpected transaction action %0h count %0h", $time, action,
                 key_count);
        errors++;
      end else begin
        want = pending_msgs.pop_front();
        got = {out_key_5, out_key_4, out_key_3, out_key_2, out_key_1, out_key_0};
        check_field("action", want.act, action);
        check_field("key_count", want.count, key_count);
        for (int i = 0; i < KEY_FIELDS; i++)
          check_field($sformatf("out_key_%0d", i), want.keys[i], got[i]);
        check_field("last", want.last, last);
      end
    end
  end

  initial begin
    snap_row_t row;
    for (int i = 0; i < DIR_ROWS; i++) snapshot_q.push_back(DIRECTED_ROWS[i]);
    gen_keys = '0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      gen_keys = next_snapshot(gen_keys);
      row = '0;
      row.keys = gen_keys;
      snapshot_q.push_back(row);
    end
    total_items = snapshot_q.size();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    while (snapshot_q.size() != 0 || key_valid) @(posedge clk);
    while (pending_msgs.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("key_set_press_release_diff_test: PASS");
    end else begin
      $display("key_set_press_release_diff_test: FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("key_set_press_release_diff_test: FAIL");
    $finish;
  end

endmodule
